// File: src/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and the digit mapping for the URL decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] LETTER_OFS = 8'd10;
    localparam logic [5:0] DIGIT_NONE = 6'd32;

    typedef enum logic [2:0] {
        ST_PLAIN = 3'b001,
        ST_PCT   = 3'b010,
        ST_DIG   = 3'b100
    } t_phase;

    // '0'-'9' -> 0..9, letters -> 10..35, anything else -> 32
    function automatic logic [5:0] f_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            t = c - CH_UPPER_A + LETTER_OFS;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            t = c - CH_LOWER_A + LETTER_OFS;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else begin
            t = {2'b00, DIGIT_NONE};
        end
        return t[5:0];
    endfunction

endpackage

// File: src/url_percent_decoder_core.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming URL percent-decoder: '+' to space, '%XY' to one byte.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata        tuser       tlast
// s_axis    in   in_byte      -           last_char
// m_axis    out  out_byte     byte_valid  end_of_text
//
// The decode is a single pass of logic into the output register, so a byte
// is taken every cycle while the output drains.
// The result of an input transfer is registered and shown in the next cycle.
// Synchronous active-low reset returns the escape phase to plain text and
// empties the output register.
// A stalled output holds its result; input is taken only when the output
// register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module url_percent_decoder_core
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] byte_valid
    output logic       o_m_axis_tlast
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bvalid;
    logic       r_last;

    logic       s_accept;
    logic       c_res;
    logic [7:0] c_byte;
    logic       c_bvalid;
    logic [7:0] c_plain;
    logic [5:0] c_dhi, c_dlo;
    logic [7:0] c_esc;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign c_plain = (i_s_axis_tdata == CH_PLUS) ? CH_SPACE : i_s_axis_tdata;
    assign c_dhi   = f_digit(r_held);
    assign c_dlo   = f_digit(i_s_axis_tdata);
    assign c_esc   = {c_dhi[3:0], 4'b0000} + {2'b00, c_dlo};

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        c_res    = 1'b0;
        c_byte   = 8'd0;
        c_bvalid = 1'b0;
        case (r_phase)
            ST_DIG: begin
                n_phase  = ST_PLAIN;
                n_held   = 8'd0;
                c_res    = 1'b1;
                c_byte   = c_esc;
                c_bvalid = 1'b1;
            end
            ST_PCT: begin
                if (!i_s_axis_tlast) begin
                    n_held  = i_s_axis_tdata;
                    n_phase = ST_DIG;
                end else begin
                    // short escape at end: drop the '%', byte handled plainly
                    n_phase = ST_PLAIN;
                    n_held  = 8'd0;
                    c_res   = 1'b1;
                    if (i_s_axis_tdata != CH_PERCENT) begin
                        c_byte   = c_plain;
                        c_bvalid = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = ST_PLAIN;
                n_held  = 8'd0;
                if (i_s_axis_tdata == CH_PERCENT) begin
                    if (i_s_axis_tlast) begin
                        c_res = 1'b1;
                    end else begin
                        n_phase = ST_PCT;
                    end
                end else begin
                    c_res    = 1'b1;
                    c_byte   = c_plain;
                    c_bvalid = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_PLAIN;
            r_held  <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_valid <= c_res;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_byte   <= c_byte;
            r_bvalid <= c_bvalid;
            r_last   <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_byte;
    assign o_m_axis_tuser  = r_bvalid;
    assign o_m_axis_tlast  = r_last;

endmodule

// File: src/upd_checker.sv
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URL decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker
    import upd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tlast && o_m_axis_tdata == 8'd0))
        else $error("empty result not at end of text");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled output changed");

    a_no_plus_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata == CH_PLUS) |=>
            !(o_m_axis_tvalid && o_m_axis_tuser && o_m_axis_tdata == CH_PLUS))
        else $error("plus passed through");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
